/* hw/rtl/xbsc_pkg.sv */
// Constants shared by the XOR basis subset counter.
`timescale 1ns / 1ps
package xbsc_pkg;

  localparam int WIDTH      = 20;
  localparam int MAX_ITEMS  = 32;

  localparam int WORD_W     = 20;
  localparam int THR_W      = 20;
  localparam int COUNT_W    = 33;
  localparam int RANK_OUT_W = 5;

  localparam int IDX_W  = (WIDTH > 1) ? $clog2(WIDTH) : 1;
  localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam int RANK_W = $clog2(WIDTH + 1);
  localparam int LESS_W = WIDTH + 1;
  localparam int SH_W   = (WIDTH + 1 + MAX_ITEMS > COUNT_W + 1) ?
                          (WIDTH + 1 + MAX_ITEMS) : (COUNT_W + 1);

endpackage

/* hw/rtl/xbsc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module xbsc_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/xor_basis_subset_count.sv */
// XOR basis subset counter: word insertion, rank and threshold subset count.
// Insertion: a word holds busy high while S_INS walks the basis down from its top bit,
//   one basis RAM read per bit, and not at all when refused after MAX_ITEMS words; a
//   last word adds S_WPRE, S_WALK, S_SPAN, S_OUT; its result strobe comes with busy low.
// Throughput: one word at a time, the next taken at the first edge with busy low; the
//   receiver cannot stall. Reset clears valid flags, counters, overflow and threshold.
`timescale 1ns / 1ps
module xor_basis_subset_count
  import xbsc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               threshold_we,
  input  logic [THR_W-1:0]   threshold,
  input  logic               start,
  output logic               busy,
  input  logic [WORD_W-1:0]  word,
  input  logic               last,
  output logic               done,
  output logic [COUNT_W-1:0] subset_count,
  output logic [RANK_OUT_W-1:0] basis_rank,
  output logic               overflow
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;
  localparam logic [2:0] S_WPRE = 3'd2;
  localparam logic [2:0] S_WALK = 3'd3;
  localparam logic [2:0] S_SPAN = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]        state;
  logic [THR_W-1:0]  thr;
  logic [WIDTH-1:0]  v;
  logic              last_q;
  logic [IDX_W-1:0]  idx;
  logic [WIDTH-1:0]  valid;
  logic [RANK_W-1:0] rank;
  logic [CNT_W-1:0]  items;
  logic              ovf;
  logic [WIDTH-1:0]  x;
  logic              live;
  logic [RANK_W-1:0] rem;
  logic [LESS_W-1:0] less;
  logic [LESS_W-1:0] span;
  logic [CNT_W-1:0]  shift;

  logic [WORD_W+WIDTH-1:0] word_ext;
  logic [WIDTH-1:0]        word_v;
  logic [THR_W+WIDTH-1:0]  thr_ext;
  logic [THR_W+WIDTH-1:0]  thr_top;
  logic [WIDTH-1:0]        thr_w;
  logic                    thr_hi;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_raddr;
  logic [WIDTH-1:0]  ram_rdata;
  logic [WIDTH-1:0]  entry;
  logic              entry_ok;
  logic [RANK_W-1:0] rem_dec;
  logic [SH_W-1:0]   shifted;
  logic              sat;

  assign word_ext = {{WIDTH{1'b0}}, word};
  assign word_v   = word_ext[WIDTH-1:0];
  assign thr_ext  = {{WIDTH{1'b0}}, thr};
  assign thr_w    = thr_ext[WIDTH-1:0];
  assign thr_top  = thr_ext >> WIDTH;
  assign thr_hi   = |thr_top;

  assign busy     = (state != S_IDLE);
  assign entry_ok = valid[idx];
  assign entry    = ram_rdata & {WIDTH{entry_ok}};
  assign rem_dec  = rem - 1'b1;
  assign ram_we   = (state == S_INS) && v[idx] && !entry_ok;

  always_comb begin
    unique case (state)
      S_IDLE:  ram_raddr = IDX_W'(WIDTH - 1);
      S_WPRE:  ram_raddr = IDX_W'(WIDTH - 1);
      S_INS:   ram_raddr = idx - 1'b1;
      S_WALK:  ram_raddr = idx - 1'b1;
      default: ram_raddr = idx;
    endcase
  end

  assign shifted = SH_W'(span) << shift;
  assign sat     = |shifted[SH_W-1:COUNT_W];

  xbsc_ram #(
    .DATA_W (WIDTH),
    .DEPTH  (WIDTH)
  ) u_basis (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx),
    .wdata (v),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= '0;
    end else if (threshold_we) begin
      thr <= threshold;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
      rank  <= '0;
      items <= '0;
      ovf   <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            v      <= word_v;
            last_q <= last;
            idx    <= IDX_W'(WIDTH - 1);
            if (items < CNT_W'(MAX_ITEMS)) begin
              state <= S_INS;
            end else begin
              ovf <= 1'b1;
              if (last) begin
                state <= S_WPRE;
              end
            end
          end
        end
        S_INS: begin
          if (v[idx] && !entry_ok) begin
            valid[idx] <= 1'b1;
            rank       <= rank + 1'b1;
            items      <= items + 1'b1;
            state      <= last_q ? S_WPRE : S_IDLE;
          end else begin
            if (v[idx]) begin
              v <= v ^ entry;
            end
            if (idx == '0) begin
              items <= items + 1'b1;
              state <= last_q ? S_WPRE : S_IDLE;
            end else begin
              idx <= idx - 1'b1;
            end
          end
        end
        S_WPRE: begin
          idx   <= IDX_W'(WIDTH - 1);
          x     <= '0;
          rem   <= rank;
          live  <= !thr_hi;
          less  <= thr_hi ? (LESS_W'(1) << rank) : '0;
          state <= S_WALK;
        end
        S_WALK: begin
          if (entry_ok) begin
            rem <= rem_dec;
          end
          if (live) begin
            if (entry_ok) begin
              if (thr_w[idx]) begin
                less <= less + (LESS_W'(1) << rem_dec);
                if (!x[idx]) begin
                  x <= x ^ entry;
                end
              end else if (x[idx]) begin
                x <= x ^ entry;
              end
            end else if (!x[idx] && thr_w[idx]) begin
              less <= less + (LESS_W'(1) << rem);
              live <= 1'b0;
            end else if (x[idx] && !thr_w[idx]) begin
              live <= 1'b0;
            end
          end
          if (idx == '0) begin
            state <= S_SPAN;
          end else begin
            idx <= idx - 1'b1;
          end
        end
        S_SPAN: begin
          span  <= (LESS_W'(1) << rank) - less;
          shift <= items - CNT_W'(rank);
          state <= S_OUT;
        end
        S_OUT: begin
          subset_count <= sat ? {COUNT_W{1'b1}} : shifted[COUNT_W-1:0];
          basis_rank   <= RANK_OUT_W'(rank);
          overflow     <= ovf;
          done         <= 1'b1;
          valid        <= '0;
          rank         <= '0;
          items        <= '0;
          ovf          <= 1'b0;
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_rank_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == rank)
    else $error("basis rank out of step with entry valid flags");

  a_rank_le_items: assert property (@(posedge clk) disable iff (rst)
    CNT_W'(rank) <= items)
    else $error("rank exceeds number of loaded words");

  a_done_after_out: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_OUT))
    else $error("result strobe without final step");

  a_cleared_after_result: assert property (@(posedge clk) disable iff (rst)
    done |-> (items == '0 && valid == '0 && !ovf))
    else $error("set state not cleared after result");

  a_write_only_empty: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !valid[idx])
    else $error("basis entry overwritten");

endmodule
